// File: src/fdm_pkg.sv
// Shared types and constants for the FAT32 directory entry matcher.
package fdm_pkg;

    // Search modes as held in the search_mode register and reported as match_kind
    localparam logic [1:0] MODE_FILE = 2'd0;
    localparam logic [1:0] MODE_DIR  = 2'd1;
    localparam logic [1:0] MODE_LIST = 2'd2;

    // Configuration register indexes
    localparam int unsigned CFG_INDEX_W = 3;
    localparam logic [CFG_INDEX_W-1:0] CFG_SEARCH_MODE   = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_WANTED_NAME   = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_WANTED_EXT    = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_ROOT_CLUSTER  = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_CLUSTER_SECTS = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_DATA_START    = 3'd5;

    localparam int unsigned CFG_DATA_W = 64;

    // Entry layout
    localparam int unsigned POS_W = 5;
    localparam logic [POS_W-1:0] POS_EXT_FIRST   = 5'd8;
    localparam logic [POS_W-1:0] POS_EXT_MID     = 5'd9;
    localparam logic [POS_W-1:0] POS_EXT_LAST    = 5'd10;
    localparam logic [POS_W-1:0] POS_ATTR        = 5'd11;
    localparam logic [POS_W-1:0] POS_CLUS_HI_LO  = 5'd20;
    localparam logic [POS_W-1:0] POS_CLUS_HI_HI  = 5'd21;
    localparam logic [POS_W-1:0] POS_CLUS_LO_LO  = 5'd26;
    localparam logic [POS_W-1:0] POS_CLUS_LO_HI  = 5'd27;
    localparam logic [POS_W-1:0] POS_DIFF        = 5'd28;
    localparam logic [POS_W-1:0] POS_LAST        = 5'd31;

    localparam logic [7:0] SPACE_BYTE     = 8'h20;
    localparam logic [7:0] ATTR_DIRECTORY = 8'd16;

    typedef struct packed {
        logic [1:0]  search_mode;
        logic [63:0] wanted_name;
        logic [23:0] wanted_ext;
        logic [31:0] root_cluster;
        logic [7:0]  cluster_sectors;
        logic [31:0] data_start_sector;
    } cfg_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       new_search;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  match_kind;
        logic [31:0] first_cluster;
        logic [31:0] first_sector;
        logic [63:0] entry_name;
        logic [3:0]  entry_index;
    } out_item_t;

    // Matched entry handed from the scanner to the result stage
    typedef struct packed {
        logic        hit;
        logic [1:0]  kind;
        logic [31:0] cluster;
        logic [31:0] cluster_offset;
        logic [63:0] name;
        logic [3:0]  index;
    } hit_t;

endpackage

// File: src/fat32_dir_entry_matcher.sv
// Top level of the FAT32 directory entry matcher.
//
// Directory sector bytes enter on the input channel (in_valid, in_stall,
// in_data), one byte per transfer. Set new_search on the first byte of a new
// search to restart at entry 0 and clear the found flag. Each 32-byte entry
// is compared against the configured name and extension under the current
// mode; at the entry's last byte a match loads one result into the output
// register (out_valid, out_stall, out_data) on the following clock edge.
// One byte is taken every cycle. The output register parts the two sides:
// bytes keep flowing while a result waits, and in_stall rises only when the
// next byte is an entry's last byte and the waiting result is still stalled.
// The first sector is the cluster offset (taken at byte 28) times sectors per
// cluster plus the data start, one 32x8 multiply before the output register.
// Configuration writes (cfg_valid, cfg_ready, cfg_index, cfg_data) are always
// ready and must be made while the block is idle, unchecked. Reset clears the
// position, entry counter and found flag, drops any pending result and sets
// the registers to their defaults (one sector per cluster, all others zero).
module fat32_dir_entry_matcher
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  fdm_pkg::in_item_t                    in_data,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output fdm_pkg::out_item_t                   out_data,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [fdm_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  logic [fdm_pkg::CFG_DATA_W-1:0]       cfg_data
);

    fdm_pkg::cfg_t cfg;
    fdm_pkg::hit_t hit;
    logic          at_last_byte;
    logic          take;

    assign cfg_ready = 1'b1;

    // Hold the byte that could report while the result slot stays blocked
    assign in_stall = at_last_byte && out_valid && out_stall;
    assign take     = in_valid && !in_stall;

    fdm_cfg_regs u_cfg_regs
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid && cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    fdm_entry_scan u_entry_scan
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .take         (take),
        .item         (in_data),
        .at_last_byte (at_last_byte),
        .hit          (hit)
    );

    fdm_result_reg u_result_reg
    (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .hit   (hit),
        .stall (out_stall),
        .valid (out_valid),
        .data  (out_data)
    );

endmodule

// File: src/fdm_cfg_regs.sv
// Configuration register file of the FAT32 directory entry matcher.
module fdm_cfg_regs
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 wr_en,
    input  logic [fdm_pkg::CFG_INDEX_W-1:0]      wr_index,
    input  logic [fdm_pkg::CFG_DATA_W-1:0]       wr_data,
    output fdm_pkg::cfg_t                        cfg
);

    fdm_pkg::cfg_t cfg_reg;
    fdm_pkg::cfg_t cfg_next;

    // Decode the write index; writes beyond the list are dropped
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (wr_index)
                fdm_pkg::CFG_SEARCH_MODE:   cfg_next.search_mode       = wr_data[1:0];
                fdm_pkg::CFG_WANTED_NAME:   cfg_next.wanted_name       = wr_data;
                fdm_pkg::CFG_WANTED_EXT:    cfg_next.wanted_ext        = wr_data[23:0];
                fdm_pkg::CFG_ROOT_CLUSTER:  cfg_next.root_cluster      = wr_data[31:0];
                fdm_pkg::CFG_CLUSTER_SECTS: cfg_next.cluster_sectors   = wr_data[7:0];
                fdm_pkg::CFG_DATA_START:    cfg_next.data_start_sector = wr_data[31:0];
                default:                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.search_mode       <= fdm_pkg::MODE_FILE;
            cfg_reg.wanted_name       <= '0;
            cfg_reg.wanted_ext        <= '0;
            cfg_reg.root_cluster      <= '0;
            cfg_reg.cluster_sectors   <= 8'd1;
            cfg_reg.data_start_sector <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// File: src/fdm_entry_scan.sv
// Byte position tracking, name/extension compare and field capture per entry.
module fdm_entry_scan
(
    input  logic              clk,
    input  logic              rst_n,
    input  fdm_pkg::cfg_t     cfg,
    input  logic              take,
    input  fdm_pkg::in_item_t item,
    output logic              at_last_byte,
    output fdm_pkg::hit_t     hit
);

    logic [fdm_pkg::POS_W-1:0] pos_reg, pos_next;
    logic [3:0]                entry_reg, entry_next;
    logic                      matching_reg, matching_next;
    logic                      found_reg, found_next;
    logic [63:0]               name_reg, name_next;
    logic [31:0]               cluster_reg, cluster_next;
    logic [31:0]               offset_reg, offset_next;

    logic [fdm_pkg::POS_W-1:0] pos_eff;
    logic [3:0]                entry_eff;
    logic                      matching_eff;
    logic                      found_eff;
    logic [63:0]               name_eff;
    logic [31:0]               cluster_eff;
    logic [7:0]                b;
    logic [7:0]                name_want;
    logic [7:0]                ext_want;
    logic                      byte_ok;
    logic                      match_now;
    logic                      report;

    assign b = item.data_byte;

    // Apply a new search before this byte is taken
    always_comb
    begin
        pos_eff      = item.new_search ? '0    : pos_reg;
        entry_eff    = item.new_search ? '0    : entry_reg;
        matching_eff = item.new_search ? 1'b1  : matching_reg;
        found_eff    = item.new_search ? 1'b0  : found_reg;
        name_eff     = item.new_search ? '0    : name_reg;
        cluster_eff  = item.new_search ? '0    : cluster_reg;
    end

    // Pick the wanted byte for this position
    always_comb
    begin
        name_want = 8'(cfg.wanted_name >> {~pos_eff[2:0], 3'b000});
        case (pos_eff)
            fdm_pkg::POS_EXT_FIRST: ext_want = cfg.wanted_ext[23:16];
            fdm_pkg::POS_EXT_MID:   ext_want = cfg.wanted_ext[15:8];
            default:                ext_want = cfg.wanted_ext[7:0];
        endcase
    end

    // Test this byte under the current mode
    always_comb
    begin
        if (pos_eff < fdm_pkg::POS_EXT_FIRST)
        begin
            byte_ok = (cfg.search_mode == fdm_pkg::MODE_LIST) || (b == name_want);
        end
        else if (pos_eff <= fdm_pkg::POS_EXT_LAST)
        begin
            byte_ok = (cfg.search_mode == fdm_pkg::MODE_DIR) ? (b == fdm_pkg::SPACE_BYTE)
                                                             : (b == ext_want);
        end
        else if (pos_eff == fdm_pkg::POS_ATTR && cfg.search_mode == fdm_pkg::MODE_DIR)
        begin
            byte_ok = (b == fdm_pkg::ATTR_DIRECTORY);
        end
        else
        begin
            byte_ok = 1'b1;
        end
    end

    assign match_now = matching_eff && byte_ok;

    // Report at the last byte when matching and, unless listing, not yet found
    assign report = (pos_eff == fdm_pkg::POS_LAST) && match_now
                    && (cfg.search_mode == fdm_pkg::MODE_FILE
                        || cfg.search_mode == fdm_pkg::MODE_DIR
                        || cfg.search_mode == fdm_pkg::MODE_LIST)
                    && (cfg.search_mode == fdm_pkg::MODE_LIST || !found_eff);

    // Advance position, capture name and cluster bytes
    always_comb
    begin
        pos_next      = pos_reg;
        entry_next    = entry_reg;
        matching_next = matching_reg;
        found_next    = found_reg;
        name_next     = name_reg;
        cluster_next  = cluster_reg;
        offset_next   = offset_reg;
        if (take)
        begin
            matching_next = match_now;
            found_next    = found_eff;
            name_next     = name_eff;
            cluster_next  = cluster_eff;
            if (pos_eff < fdm_pkg::POS_EXT_FIRST)
            begin
                name_next = {name_eff[55:0], b};
            end
            case (pos_eff)
                fdm_pkg::POS_CLUS_LO_LO: cluster_next[7:0]   = b;
                fdm_pkg::POS_CLUS_LO_HI: cluster_next[15:8]  = b;
                fdm_pkg::POS_CLUS_HI_LO: cluster_next[23:16] = b;
                fdm_pkg::POS_CLUS_HI_HI: cluster_next[31:24] = b;
                default:                 cluster_next = cluster_next;
            endcase
            // Cluster is complete here; hold its offset from the root
            if (pos_eff == fdm_pkg::POS_DIFF)
            begin
                offset_next = cluster_eff - cfg.root_cluster;
            end
            if (pos_eff == fdm_pkg::POS_LAST)
            begin
                matching_next = 1'b1;
                pos_next      = '0;
                entry_next    = entry_eff + 4'd1;
                if (report && cfg.search_mode != fdm_pkg::MODE_LIST)
                begin
                    found_next = 1'b1;
                end
            end
            else
            begin
                pos_next   = pos_eff + 5'd1;
                entry_next = entry_eff;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg      <= '0;
            entry_reg    <= '0;
            matching_reg <= 1'b1;
            found_reg    <= 1'b0;
            name_reg     <= '0;
            cluster_reg  <= '0;
            offset_reg   <= '0;
        end
        else
        begin
            pos_reg      <= pos_next;
            entry_reg    <= entry_next;
            matching_reg <= matching_next;
            found_reg    <= found_next;
            name_reg     <= name_next;
            cluster_reg  <= cluster_next;
            offset_reg   <= offset_next;
        end
    end

    assign at_last_byte = (pos_reg == fdm_pkg::POS_LAST);

    always_comb
    begin
        hit.hit            = take && report;
        hit.kind           = cfg.search_mode;
        hit.cluster        = cluster_eff;
        hit.cluster_offset = offset_reg;
        hit.name           = name_eff;
        hit.index          = entry_eff;
    end

endmodule

// File: src/fdm_result_reg.sv
// Sector computation and output register of the FAT32 directory entry matcher.
module fdm_result_reg
(
    input  logic               clk,
    input  logic               rst_n,
    input  fdm_pkg::cfg_t      cfg,
    input  fdm_pkg::hit_t      hit,
    input  logic               stall,
    output logic               valid,
    output fdm_pkg::out_item_t data
);

    logic               valid_reg, valid_next;
    fdm_pkg::out_item_t data_reg, data_next;
    logic [39:0]        product;

    // Scale the cluster offset to sectors and add the data area base
    assign product = hit.cluster_offset * cfg.cluster_sectors;

    always_comb
    begin
        valid_next = valid_reg;
        data_next  = data_reg;
        if (hit.hit)
        begin
            valid_next              = 1'b1;
            data_next.match_kind    = hit.kind;
            data_next.first_cluster = hit.cluster;
            data_next.first_sector  = product[31:0] + cfg.data_start_sector;
            data_next.entry_name    = hit.name;
            data_next.entry_index   = hit.index;
        end
        else if (!stall)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign valid = valid_reg;
    assign data  = data_reg;

endmodule
